FILE: src/sso_pkg.sv
// Shared types, constants and the sine table function of the servo sine oscillator.
package sso_pkg;

  localparam int SINE_ENTRIES_DEF   = 1024;
  localparam int SINE_FRAC_BITS_DEF = 15;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  localparam logic [15:0]        SAMPLING_RST  = 16'd30;
  localparam logic [15:0]        PERIOD_RST    = 16'd2000;
  localparam logic [7:0]         AMPLITUDE_RST = 8'd45;
  localparam logic signed [9:0]  POS_RST       = 10'sd90;
  localparam logic [10:0]        DUTY_RST      = 11'd250;

  // Duty is 250 + floor(angle * 50 / 9), with the division done as a reciprocal multiply.
  localparam logic [10:0] DUTY_BASE  = 11'd250;
  localparam logic [26:0] DUTY_RECIP = 27'd364100;
  localparam int          DUTY_SHIFT = 16;

  localparam logic [15:0] MS_PER_S = 16'd1000;

  localparam int          DIV_NUM_W     = 34;
  localparam int          DIV_STEPS_W   = 5;
  localparam logic [4:0]  STEPS_N       = 5'd8;
  localparam logic [4:0]  STEPS_STEP    = 5'd17;
  localparam logic [4:0]  STEPS_SLEW    = 5'd14;
  localparam logic [33:0] STEP_DIVIDEND = 34'h1_0000_0000;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_POS   = 2'd1,
    OP_CLR_PHASE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_SAMPLING  = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_AMPLITUDE = 3'd2,
    CFG_OFFSET    = 3'd3,
    CFG_PHASE_OFS = 3'd4,
    CFG_TRIM      = 3'd5,
    CFG_SLEW      = 3'd6,
    CFG_CONTROL   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_N    = 2'd0,
    DIV_STEP = 2'd1,
    DIV_SLEW = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     take_sample;
    logic     clear_phase;
    logic     load_index;
    logic     load_sine;
    logic     load_mac;
    logic     load_req_sine;
    logic     load_req_target;
    logic     div_start;
    div_sel_e div_sel;
    logic     write_pos;
    logic     load_duty;
    logic     advance_phase;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic tick_due;
    logic stopped;
    logic attached;
    logic slew_on;
    logic div_done;
  } dp_status_t;

  // Sine of a 32-bit turn fraction in signed Q1.frac, from a Q30 Taylor series.
  function automatic int sine_entry(input longint phase, input int frac);
    longint     r;
    longint     x;
    longint     x2;
    longint     term;
    longint     sum;
    longint     half;
    longint     mag;
    longint     maxv;
    logic [1:0] quad;
    quad = 2'(phase >>> 30);
    r    = phase & longint'(32'h3FFF_FFFF);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x    = (r * Q30_HALF_PI) >>> 30;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    half = longint'(1) <<< (29 - frac);
    mag  = (sum + half) >>> (30 - frac);
    maxv = (longint'(1) <<< frac) - 1;
    if (mag > maxv) begin
      mag = maxv;
    end
    return int'(quad[1] ? -mag : mag);
  endfunction

endpackage

FILE: src/sso_div.sv
// Restoring divider that produces two quotient bits per cycle.
module sso_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sso_pkg::DIV_NUM_W-1:0]    dividend_i,
  input  logic [15:0]                      divisor_i,
  input  logic [sso_pkg::DIV_STEPS_W-1:0]  steps_i,
  output logic [sso_pkg::DIV_NUM_W-1:0]    quotient_o,
  output logic                             done_o
);

  logic [sso_pkg::DIV_NUM_W-1:0]   num_q, num_d;
  logic [15:0]                     rem_q, rem_d;
  logic [15:0]                     den_q;
  logic [sso_pkg::DIV_STEPS_W-1:0] cnt_q;
  logic                            done_q;

  logic [16:0] t1, t2;
  logic        b1, b2;
  logic [15:0] r1;

  always_comb begin
    t1    = {rem_q, num_q[sso_pkg::DIV_NUM_W-1]};
    b1    = t1 >= {1'b0, den_q};
    r1    = b1 ? 16'(t1 - {1'b0, den_q}) : t1[15:0];
    t2    = {r1, num_q[sso_pkg::DIV_NUM_W-2]};
    b2    = t2 >= {1'b0, den_q};
    rem_d = b2 ? 16'(t2 - {1'b0, den_q}) : t2[15:0];
    num_d = {num_q[sso_pkg::DIV_NUM_W-3:0], b1, b2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= steps_i;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == sso_pkg::DIV_STEPS_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule

FILE: src/sso_datapath.sv
// Datapath: configuration, oscillator state, sine lookup, slew limiter and duty.
module sso_datapath #(
  parameter int SINE_ENTRIES   = sso_pkg::SINE_ENTRIES_DEF,
  parameter int SINE_FRAC_BITS = sso_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [1:0]          operation_i,
  input  logic [31:0]         now_ms_i,
  input  logic signed [9:0]   target_position_i,
  input  sso_pkg::dp_cmd_t    cmd_i,
  output sso_pkg::dp_status_t status_o,
  output logic                wrote_o,
  output logic signed [9:0]   position_o,
  output logic [7:0]          angle_o,
  output logic [10:0]         duty_o
);

  localparam int IdxW  = $clog2(SINE_ENTRIES);
  localparam int SineW = SINE_FRAC_BITS + 1;
  localparam int MacW  = SINE_FRAC_BITS + 11;
  localparam int ProdW = 33 + IdxW;

  function automatic logic [7:0] clamp_angle(input logic signed [9:0] pos,
                                             input logic signed [7:0] trim);
    logic signed [10:0] a;
    a = 11'(pos) + 11'(trim);
    if (a < 11'sd0) begin
      return 8'd0;
    end else if (a > 11'sd180) begin
      return 8'd180;
    end
    return a[7:0];
  endfunction

  logic signed [SineW-1:0] sine_tab [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
    localparam longint Phase = (longint'(g) <<< 32) / SINE_ENTRIES;
    assign sine_tab[g] = SineW'(sso_pkg::sine_entry(Phase, SINE_FRAC_BITS));
  end

  logic [15:0]        sp_q;
  logic [15:0]        per_q;
  logic [7:0]         amp_q;
  logic signed [8:0]  ofs_q;
  logic [15:0]        phoff_q;
  logic signed [7:0]  trim_q;
  logic [11:0]        slew_q;
  logic [2:0]         ctl_q;

  logic [1:0]         op_q;
  logic [31:0]        now_q;
  logic signed [9:0]  tgt_q;

  logic [31:0]        phase_q;
  logic [31:0]        last_sample_q;
  logic [31:0]        last_cmd_q;
  logic signed [9:0]  pos_q, pos_d;
  logic [10:0]        duty_q, duty_d;
  logic               wrote_q;

  logic [IdxW-1:0]         idx_q, idx_d;
  logic signed [SineW-1:0] sine_q;
  logic signed [MacW-1:0]  mac_q, mac_d;
  logic signed [9:0]       req_q, req_d;

  logic                wrote_out_q;
  logic signed [9:0]   pos_out_q;
  logic [7:0]          angle_out_q;
  logic [10:0]         duty_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= sso_pkg::SAMPLING_RST;
      per_q   <= sso_pkg::PERIOD_RST;
      amp_q   <= sso_pkg::AMPLITUDE_RST;
      ofs_q   <= '0;
      phoff_q <= '0;
      trim_q  <= '0;
      slew_q  <= '0;
      ctl_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (sso_pkg::cfg_reg_e'(cfg_index_i))
        sso_pkg::CFG_SAMPLING:  sp_q    <= cfg_data_i;
        sso_pkg::CFG_PERIOD:    per_q   <= cfg_data_i;
        sso_pkg::CFG_AMPLITUDE: amp_q   <= cfg_data_i[7:0];
        sso_pkg::CFG_OFFSET:    ofs_q   <= cfg_data_i[8:0];
        sso_pkg::CFG_PHASE_OFS: phoff_q <= cfg_data_i;
        sso_pkg::CFG_TRIM:      trim_q  <= cfg_data_i[7:0];
        sso_pkg::CFG_SLEW:      slew_q  <= cfg_data_i[11:0];
        sso_pkg::CFG_CONTROL:   ctl_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic                           div_start;
  logic [sso_pkg::DIV_NUM_W-1:0]  dividend;
  logic [15:0]                    divisor;
  logic [sso_pkg::DIV_STEPS_W-1:0] steps;
  logic [sso_pkg::DIV_NUM_W-1:0]  quot;
  logic                           div_done;

  logic [31:0]        ph;
  logic [ProdW-1:0]   idx_prod;
  logic signed [MacW-1:0] amp_ext, sine_ext, ofs_ext;
  logic               mac_neg;
  logic [MacW-1:0]    mac_mag, rnd;
  logic [10:0]        rnd11;
  logic signed [11:0] sval, req_w;
  logic [31:0]        elapsed;
  logic [15:0]        e_sat;
  logic [27:0]        slew_prod;
  logic [10:0]        lim;
  logic signed [11:0] lim_s, diff;
  logic [7:0]         angle_now;
  logic [26:0]        duty_prod;

  always_comb begin
    ph       = phase_q + {phoff_q, 16'b0};
    idx_prod = ProdW'(ph) * ProdW'(SINE_ENTRIES);
    idx_d    = idx_prod[32 +: IdxW];

    amp_ext  = MacW'($signed({1'b0, amp_q}));
    sine_ext = MacW'(sine_q);
    ofs_ext  = MacW'(ofs_q);
    mac_d    = amp_ext * sine_ext + (ofs_ext <<< SINE_FRAC_BITS);

    mac_neg = mac_q[MacW-1];
    mac_mag = mac_neg ? MacW'(-mac_q) : MacW'(mac_q);
    rnd     = (mac_mag + (MacW'(1) << (SINE_FRAC_BITS - 1))) >> SINE_FRAC_BITS;
    rnd11   = rnd[10:0];
    sval    = (mac_neg ^ ctl_q[1]) ? -$signed({1'b0, rnd11}) : $signed({1'b0, rnd11});
    req_w   = sval + 12'sd90;
    if (req_w > 12'sd511) begin
      req_d = 10'sd511;
    end else if (req_w < -12'sd512) begin
      req_d = -10'sd512;
    end else begin
      req_d = req_w[9:0];
    end

    elapsed   = now_q - last_cmd_q;
    e_sat     = (elapsed[31:16] != '0) ? 16'hFFFF : elapsed[15:0];
    slew_prod = 28'(e_sat) * 28'(slew_q);

    div_start = cmd_i.div_start;
    unique case (cmd_i.div_sel)
      sso_pkg::DIV_N: begin
        dividend = {per_q, 18'b0};
        divisor  = (sp_q == '0) ? 16'd1 : sp_q;
        steps    = sso_pkg::STEPS_N;
      end
      sso_pkg::DIV_STEP: begin
        dividend = sso_pkg::STEP_DIVIDEND;
        divisor  = (quot[15:0] == '0) ? 16'd1 : quot[15:0];
        steps    = sso_pkg::STEPS_STEP;
      end
      sso_pkg::DIV_SLEW: begin
        dividend = {slew_prod, 6'b0};
        divisor  = sso_pkg::MS_PER_S;
        steps    = sso_pkg::STEPS_SLEW;
      end
      default: begin
        dividend = '0;
        divisor  = 16'd1;
        steps    = '0;
      end
    endcase

    if (quot[33:11] != '0) begin
      lim = 11'h7FF;
    end else if (quot[10:0] == '0) begin
      lim = 11'd1;
    end else begin
      lim = quot[10:0];
    end
    lim_s = $signed({1'b0, lim});
    diff  = 12'(req_q) - 12'(pos_q);
    if (slew_q == '0) begin
      pos_d = req_q;
    end else if (diff > lim_s) begin
      pos_d = 10'(12'(pos_q) + lim_s);
    end else if (diff < -lim_s) begin
      pos_d = 10'(12'(pos_q) - lim_s);
    end else begin
      pos_d = req_q;
    end

    angle_now = clamp_angle(pos_q, trim_q);
    duty_prod = 27'(angle_now) * sso_pkg::DUTY_RECIP;
    duty_d    = sso_pkg::DUTY_BASE + 11'(duty_prod >> sso_pkg::DUTY_SHIFT);
  end

  sso_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .steps_i    (steps),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      last_sample_q <= '0;
      last_cmd_q    <= '0;
      pos_q         <= sso_pkg::POS_RST;
      duty_q        <= sso_pkg::DUTY_RST;
      wrote_q       <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        wrote_q <= 1'b0;
      end
      if (cmd_i.take_sample) begin
        last_sample_q <= now_q;
      end
      if (cmd_i.clear_phase) begin
        phase_q <= '0;
      end else if (cmd_i.advance_phase) begin
        phase_q <= phase_q + quot[31:0];
      end
      if (cmd_i.write_pos) begin
        pos_q      <= pos_d;
        last_cmd_q <= now_q;
        wrote_q    <= 1'b1;
      end
      if (cmd_i.load_duty) begin
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      now_q <= now_ms_i;
      tgt_q <= target_position_i;
    end
    if (cmd_i.load_index) begin
      idx_q <= idx_d;
    end
    if (cmd_i.load_sine) begin
      sine_q <= sine_tab[idx_q];
    end
    if (cmd_i.load_mac) begin
      mac_q <= mac_d;
    end
    if (cmd_i.load_req_sine) begin
      req_q <= req_d;
    end else if (cmd_i.load_req_target) begin
      req_q <= tgt_q;
    end
    if (cmd_i.load_out) begin
      wrote_out_q <= wrote_q;
      pos_out_q   <= pos_q;
      angle_out_q <= angle_now;
      duty_out_q  <= duty_q;
    end
  end

  always_comb begin
    status_o.op       = sso_pkg::op_e'(op_q);
    status_o.tick_due = (now_q - last_sample_q) > 32'(sp_q);
    status_o.stopped  = ctl_q[0];
    status_o.attached = ctl_q[2];
    status_o.slew_on  = slew_q != '0;
    status_o.div_done = div_done;
  end

  assign wrote_o    = wrote_out_q;
  assign position_o = pos_out_q;
  assign angle_o    = angle_out_q;
  assign duty_o     = duty_out_q;

endmodule

FILE: src/sso_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module sso_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sso_pkg::dp_status_t status_i,
  output sso_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_DECODE    = 12'b0000_0000_0010,
    ST_SINE      = 12'b0000_0000_0100,
    ST_MAC       = 12'b0000_0000_1000,
    ST_ROUND     = 12'b0000_0001_0000,
    ST_WRITE     = 12'b0000_0010_0000,
    ST_SLEW_WAIT = 12'b0000_0100_0000,
    ST_APPLY     = 12'b0000_1000_0000,
    ST_DUTY      = 12'b0001_0000_0000,
    ST_N_WAIT    = 12'b0010_0000_0000,
    ST_STEP_WAIT = 12'b0100_0000_0000,
    ST_RESULT    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   after_write;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.div_sel = sso_pkg::DIV_N;
    in_ready_o  = 1'b0;
    after_write = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status_i.op)
          sso_pkg::OP_TICK: begin
            if (status_i.tick_due) begin
              cmd_o.take_sample = 1'b1;
              if (status_i.stopped) begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_sel   = sso_pkg::DIV_N;
                state_d         = ST_N_WAIT;
              end else begin
                cmd_o.load_index = 1'b1;
                state_d          = ST_SINE;
              end
            end else begin
              state_d = ST_RESULT;
            end
          end
          sso_pkg::OP_SET_POS: begin
            cmd_o.load_req_target = 1'b1;
            state_d               = ST_WRITE;
          end
          sso_pkg::OP_CLR_PHASE: begin
            cmd_o.clear_phase = 1'b1;
            state_d           = ST_RESULT;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_SINE: begin
        cmd_o.load_sine = 1'b1;
        state_d         = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.load_mac = 1'b1;
        state_d        = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.load_req_sine = 1'b1;
        state_d             = ST_WRITE;
      end
      ST_WRITE: begin
        if (!status_i.attached) begin
          after_write = 1'b1;
        end else if (status_i.slew_on) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = sso_pkg::DIV_SLEW;
          state_d         = ST_SLEW_WAIT;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_SLEW_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.write_pos = 1'b1;
        state_d         = ST_DUTY;
      end
      ST_DUTY: begin
        cmd_o.load_duty = 1'b1;
        after_write     = 1'b1;
      end
      ST_N_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = sso_pkg::DIV_STEP;
          state_d         = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.advance_phase = 1'b1;
          state_d             = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (after_write) begin
      if (status_i.op == sso_pkg::OP_TICK) begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sso_pkg::DIV_N;
        state_d         = ST_N_WAIT;
      end else begin
        state_d = ST_RESULT;
      end
    end

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/servo_sine_oscillator_core.sv
// Top level of the servo sine oscillator: controller, datapath and checks.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    operation_i, now_ms_i, target_position_i
//   out      output     out_valid_o / out_ready_i  wrote_o, position_o, angle_o, duty_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One item is worked at a time; the shared two-bit-per-cycle divider sets the length.
// A set-position item uses the divider only for the slew limiter, when attached with it on.
// A due tick runs the sine lookup and write unless stopped, then the period and step divisions.
// Other items skip the divider. A new item is taken while a result waits in the output register.
// Reset is asynchronous and active low; the sine table is constant and needs no fill.
module servo_sine_oscillator_core #(
  parameter int SINE_ENTRIES   = sso_pkg::SINE_ENTRIES_DEF,
  parameter int SINE_FRAC_BITS = sso_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [31:0]       now_ms_i,
  input  logic signed [9:0] target_position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              wrote_o,
  output logic signed [9:0] position_o,
  output logic [7:0]        angle_o,
  output logic [10:0]       duty_o
);

  sso_pkg::dp_cmd_t    cmd;
  sso_pkg::dp_status_t status;

  sso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sso_datapath #(
    .SINE_ENTRIES   (SINE_ENTRIES),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .now_ms_i          (now_ms_i),
    .target_position_i (target_position_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .wrote_o           (wrote_o),
    .position_o        (position_o),
    .angle_o           (angle_o),
    .duty_o            (duty_o)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A second transfer was accepted while an item was in work.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("A result appeared without an item in work.");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o <= 8'd180))
    else $error("The angle left the range 0 to 180.");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_o >= 11'd250 && duty_o <= 11'd1250))
    else $error("The duty left the range 250 to 1250.");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the servo sine oscillator core, with a cycle-free predictor.
module tb;
  import sso_pkg::*;

  localparam int          ENTRIES     = SINE_ENTRIES_DEF;
  localparam int          FRAC        = SINE_FRAC_BITS_DEF;
  localparam longint      TURN_Q30    = 64'sd1073741824;
  localparam longint      QUARTER_Q30 = 64'sd1686629713;
  localparam logic [63:0] ONE_TURN    = 64'h1_0000_0000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [2:0]  CTRL_STOP   = 3'b001;
  localparam logic [2:0]  CTRL_REV    = 3'b010;
  localparam logic [2:0]  CTRL_ATT    = 3'b100;
  localparam int          MAX_GAP     = 13;

  typedef struct {
    logic [15:0]       sampling;
    logic [15:0]       period;
    logic [7:0]        amplitude;
    logic signed [8:0] offset;
    logic [15:0]       phase_ofs;
    logic signed [7:0] trim;
    logic [11:0]       slew;
    logic [2:0]        control;
  } osc_cfg_t;

  typedef struct packed {
    logic              wrote;
    logic signed [9:0] position;
    logic [7:0]        angle;
    logic [10:0]       duty;
  } servo_result_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              cfg_we_i          = 1'b0;
  logic [2:0]        cfg_index_i       = '0;
  logic [15:0]       cfg_data_i        = '0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i       = '0;
  logic [31:0]       now_ms_i          = '0;
  logic signed [9:0] target_position_i = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic              wrote_o;
  logic signed [9:0] position_o;
  logic [7:0]        angle_o;
  logic [10:0]       duty_o;

  servo_sine_oscillator_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .now_ms_i          (now_ms_i),
    .target_position_i (target_position_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .wrote_o           (wrote_o),
    .position_o        (position_o),
    .angle_o           (angle_o),
    .duty_o            (duty_o)
  );

  int            sine_q15 [ENTRIES];
  osc_cfg_t      cfg_now;
  logic [31:0]   phase_turns;
  logic [31:0]   sample_stamp;
  logic [31:0]   command_stamp;
  int            servo_pos;
  int            servo_duty;
  servo_result_t expected_servo [$];
  int            mismatch_count = 0;
  logic [31:0]   clock_ms       = '0;
  bit            sender_gaps    = 1'b1;
  bit            receiver_stalls = 1'b1;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic int sine_point(int unsigned i);
    longint p;
    longint r;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint mag;
    p = (longint'(i) << 32) / ENTRIES;
    r = p & longint'(32'h3FFF_FFFF);
    if (p[30]) begin
      r = TURN_Q30 - r;
    end
    x    = (r * QUARTER_Q30) >>> 30;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
      sum  = (k % 2 == 1) ? sum - term : sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (sum + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (mag > (longint'(1) << FRAC) - 1) begin
      mag = (longint'(1) << FRAC) - 1;
    end
    return int'(p[31] ? -mag : mag);
  endfunction

  function automatic int servo_angle();
    int a;
    a = servo_pos + int'(cfg_now.trim);
    if (a < 0) begin
      a = 0;
    end
    if (a > 180) begin
      a = 180;
    end
    return a;
  endfunction

  function automatic bit drive_servo(int req, logic [31:0] stamp);
    logic [31:0] elapsed;
    int          lim;
    int          diff;
    if ((cfg_now.control & CTRL_ATT) == '0) begin
      return 1'b0;
    end
    if (req < -512) begin
      req = -512;
    end
    if (req > 511) begin
      req = 511;
    end
    if (cfg_now.slew != '0) begin
      elapsed = stamp - command_stamp;
      if (elapsed > 32'd65535) begin
        elapsed = 32'd65535;
      end
      lim = int'((elapsed * 32'(cfg_now.slew)) / 32'd1000);
      if (lim < 1) begin
        lim = 1;
      end
      diff = req - servo_pos;
      if (diff > lim) begin
        servo_pos = servo_pos + lim;
      end else if (diff < -lim) begin
        servo_pos = servo_pos - lim;
      end else begin
        servo_pos = req;
      end
    end else begin
      servo_pos = req;
    end
    command_stamp = stamp;
    servo_duty    = 250 + (servo_angle() * 50) / 9;
    return 1'b1;
  endfunction

  function automatic servo_result_t predict_item(logic [1:0] op, logic [31:0] stamp,
                                                 logic signed [9:0] target);
    servo_result_t res;
    logic [31:0]   d;
    logic [31:0]   n;
    logic [31:0]   ph;
    int            idx;
    longint        v;
    int            pos;
    res.wrote = 1'b0;
    if (op == OP_TICK) begin
      if ((stamp - sample_stamp) > 32'(cfg_now.sampling)) begin
        d            = (cfg_now.sampling == '0) ? 32'd1 : 32'(cfg_now.sampling);
        n            = 32'(cfg_now.period) / d;
        sample_stamp = stamp;
        if ((cfg_now.control & CTRL_STOP) == '0) begin
          ph  = phase_turns + {cfg_now.phase_ofs, 16'h0000};
          idx = int'((longint'(ph) * ENTRIES) >>> 32);
          v   = longint'(cfg_now.amplitude) * longint'(sine_q15[idx])
              + longint'(cfg_now.offset) * (longint'(1) << FRAC);
          if (v >= 0) begin
            pos = int'((v + (longint'(1) << (FRAC - 1))) >>> FRAC);
          end else begin
            pos = -int'((-v + (longint'(1) << (FRAC - 1))) >>> FRAC);
          end
          if ((cfg_now.control & CTRL_REV) != '0) begin
            pos = -pos;
          end
          res.wrote = drive_servo(pos + 90, stamp);
        end
        if (n == '0) begin
          n = 32'd1;
        end
        phase_turns = phase_turns + 32'(ONE_TURN / 64'(n));
      end
    end else if (op == OP_SET_POS) begin
      res.wrote = drive_servo(int'(target), stamp);
    end else if (op == OP_CLR_PHASE) begin
      phase_turns = '0;
    end
    res.position = 10'(servo_pos);
    res.angle    = 8'(servo_angle());
    res.duty     = 11'(servo_duty);
    return res;
  endfunction

  function automatic logic [15:0] reg_word(osc_cfg_t c, cfg_reg_e r);
    case (r)
      CFG_SAMPLING:  return c.sampling;
      CFG_PERIOD:    return c.period;
      CFG_AMPLITUDE: return 16'(c.amplitude);
      CFG_OFFSET:    return 16'(c.offset);
      CFG_PHASE_OFS: return c.phase_ofs;
      CFG_TRIM:      return 16'(c.trim);
      CFG_SLEW:      return 16'(c.slew);
      CFG_CONTROL:   return 16'(c.control);
      default:       return '0;
    endcase
  endfunction

  function automatic osc_cfg_t reset_cfg();
    osc_cfg_t c;
    c.sampling  = SAMPLING_RST;
    c.period    = PERIOD_RST;
    c.amplitude = AMPLITUDE_RST;
    c.offset    = '0;
    c.phase_ofs = '0;
    c.trim      = '0;
    c.slew      = '0;
    c.control   = '0;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic check_result();
    servo_result_t want;
    if (expected_servo.size() == 0) begin
      report_mismatch("result transfer with no item outstanding");
      return;
    end
    want = expected_servo.pop_front();
    if (wrote_o !== want.wrote) begin
      report_mismatch($sformatf("wrote %0b, expected %0b", wrote_o, want.wrote));
    end
    if (position_o !== want.position) begin
      report_mismatch($sformatf("position %0d, expected %0d", position_o, want.position));
    end
    if (angle_o !== want.angle) begin
      report_mismatch($sformatf("angle %0d, expected %0d", angle_o, want.angle));
    end
    if (duty_o !== want.duty) begin
      report_mismatch($sformatf("duty %0d, expected %0d", duty_o, want.duty));
    end
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = receiver_stalls ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && rst_ni)) @(posedge clk_i);
      check_result();
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] stamp, logic signed [9:0] target);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    now_ms_i          <= stamp;
    target_position_i <= target;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_servo.push_back(predict_item(op, stamp, target));
  endtask

  task automatic tick_after(int delta);
    clock_ms = clock_ms + delta;
    send_item(OP_TICK, clock_ms, 10'($urandom()));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_servo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(osc_cfg_t c);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= reg_word(c, r);
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
    cfg_now = c;
  endtask

  task automatic test_detached();
    send_item(OP_TICK, clock_ms, 10'sd0);
    tick_after(31);
    tick_after(30);
    send_item(OP_SET_POS, clock_ms, 10'sd0);
    wait_for_results();
  endtask

  task automatic test_set_position();
    osc_cfg_t c;
    c         = reset_cfg();
    c.control = CTRL_ATT;
    c.trim    = 8'sd90;
    load_config(c);
    send_item(OP_SET_POS, clock_ms, 10'sd511);
    send_item(OP_SET_POS, clock_ms, -10'sd512);
    send_item(OP_SET_POS, clock_ms, 10'sd0);
    send_item(OP_SET_POS, clock_ms, -10'sd1);
    wait_for_results();
    c.trim = -8'sd90;
    load_config(c);
    send_item(OP_SET_POS, clock_ms, 10'sd0);
    send_item(OP_SET_POS, clock_ms, 10'sd180);
    wait_for_results();
  endtask

  task automatic test_tick_cases();
    osc_cfg_t c;
    c           = reset_cfg();
    c.sampling  = '0;
    c.period    = '0;
    c.amplitude = 8'd180;
    c.offset    = 9'sd180;
    c.phase_ofs = 16'hFFFF;
    c.control   = CTRL_ATT | CTRL_REV;
    load_config(c);
    tick_after(1);
    tick_after(0);
    send_item(OP_CLR_PHASE, clock_ms, 10'sd0);
    wait_for_results();
    c.sampling  = 16'd10;
    c.period    = 16'd40;
    c.offset    = -9'sd180;
    c.phase_ofs = 16'h4000;
    c.control   = CTRL_ATT;
    load_config(c);
    repeat (4) tick_after(11);
    tick_after(10);
    clock_ms = 32'hFFFF_FFF0;
    tick_after(0);
    clock_ms = 32'd5;
    tick_after(0);
    wait_for_results();
    c.control = CTRL_ATT | CTRL_STOP;
    load_config(c);
    tick_after(11);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, -10'sd1);
    wait_for_results();
  endtask

  task automatic test_slew();
    osc_cfg_t c;
    c         = reset_cfg();
    c.control = CTRL_ATT;
    c.slew    = 12'd1;
    load_config(c);
    clock_ms = clock_ms + 5;
    send_item(OP_SET_POS, clock_ms, 10'sd180);
    send_item(OP_SET_POS, clock_ms, 10'sd180);
    clock_ms = clock_ms + 100000;
    send_item(OP_SET_POS, clock_ms, -10'sd512);
    wait_for_results();
    c.slew = 12'd4095;
    load_config(c);
    clock_ms = clock_ms + 1;
    send_item(OP_SET_POS, clock_ms, 10'sd511);
    wait_for_results();
  endtask

  function automatic osc_cfg_t random_cfg(int unsigned mode);
    osc_cfg_t c;
    if (mode == 0) begin
      c.sampling  = '0;
      c.period    = '0;
      c.amplitude = '0;
      c.offset    = -9'sd180;
      c.phase_ofs = '0;
      c.trim      = -8'sd90;
      c.slew      = '0;
      c.control   = CTRL_ATT;
    end else if (mode == 1) begin
      c.sampling  = 16'hFFFF;
      c.period    = 16'hFFFF;
      c.amplitude = 8'd180;
      c.offset    = 9'sd180;
      c.phase_ofs = 16'hFFFF;
      c.trim      = 8'sd90;
      c.slew      = 12'hFFF;
      c.control   = CTRL_ATT | CTRL_REV | CTRL_STOP;
    end else begin
      case ($urandom_range(0, 3))
        0:       c.sampling = '0;
        1:       c.sampling = 16'($urandom_range(1, 60));
        2:       c.sampling = 16'($urandom_range(60, 2000));
        default: c.sampling = 16'($urandom());
      endcase
      if ($urandom_range(0, 1) == 0) begin
        c.period = 16'($urandom());
      end else begin
        c.period = 16'(int'(c.sampling) * int'($urandom_range(1, 200)));
      end
      c.amplitude = 8'($urandom_range(0, 180));
      c.offset    = 9'(int'($urandom_range(0, 360)) - 180);
      c.phase_ofs = 16'($urandom());
      c.trim      = 8'(int'($urandom_range(0, 180)) - 90);
      case ($urandom_range(0, 2))
        0:       c.slew = '0;
        1:       c.slew = 12'($urandom_range(1, 30));
        default: c.slew = 12'($urandom_range(0, 4095));
      endcase
      c.control = '0;
      if ($urandom_range(0, 4) == 0) begin
        c.control = c.control | CTRL_STOP;
      end
      if ($urandom_range(0, 1) == 0) begin
        c.control = c.control | CTRL_REV;
      end
      if ($urandom_range(0, 5) != 0) begin
        c.control = c.control | CTRL_ATT;
      end
    end
    return c;
  endfunction

  task automatic random_item();
    int unsigned pick;
    int          delta;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0, 1:    delta = int'(cfg_now.sampling) + int'($urandom_range(0, 4)) - 2;
        2:       delta = int'($urandom_range(0, 2 * int'(cfg_now.sampling) + 20));
        default: delta = int'($urandom_range(0, 200000));
      endcase
      if (delta < 0) begin
        delta = 0;
      end
      tick_after(delta);
    end else if (pick < 85) begin
      clock_ms = clock_ms + $urandom_range(0, 50);
      send_item(OP_SET_POS, clock_ms, 10'($urandom()));
    end else if (pick < 91) begin
      send_item(OP_CLR_PHASE, $urandom(), 10'($urandom()));
    end else if (pick < 95) begin
      send_item(OP_UNUSED, $urandom(), 10'($urandom()));
    end else begin
      clock_ms = $urandom();
      tick_after(0);
    end
  endtask

  task automatic test_random();
    for (int unsigned mode = 0; mode < 12; mode++) begin
      load_config(random_cfg(mode));
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      repeat (104) random_item();
      wait_for_results();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      sine_q15[i] = sine_point(i);
    end
    cfg_now       = reset_cfg();
    phase_turns   = '0;
    sample_stamp  = '0;
    command_stamp = '0;
    servo_pos     = int'(POS_RST);
    servo_duty    = int'(DUTY_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_detached();
    test_set_position();
    test_tick_cases();
    test_slew();
    test_random();
    wait_for_results();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sso_pkg.sv
src/sso_div.sv
src/sso_datapath.sv
src/sso_ctrl.sv
src/servo_sine_oscillator_core.sv
test/tb.sv
